@@ rtl/pprc_pkg.sv @@
// Shared types and codes for the priority prefix rule classifier.
package pprc_pkg;

   localparam int FIELDS          = 4;
   localparam int KEY_PORT_BITS   = 32;
   localparam int LEN_BITS        = 6;
   localparam int PRIO_BITS       = 32;
   localparam int VALUE_PORT_BITS = 32;

   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_ADD_NEXT = 2'd1;
   localparam logic [1:0] ACT_SEAL     = 2'd2;
   localparam logic [1:0] ACT_LOOKUP   = 2'd3;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_PHASE    = 2'd1;
   localparam logic [1:0] STS_NOMATCH  = 2'd2;
   localparam logic [1:0] STS_FULL     = 2'd3;

   localparam logic signed [PRIO_BITS-1:0] PRIO_MAX = 32'sh7fff_ffff;

   typedef logic [VALUE_PORT_BITS-1:0] value_word_type;

   typedef struct packed {
      logic [1:0]                               action;
      logic [FIELDS-1:0][KEY_PORT_BITS-1:0]     key;
      logic [FIELDS-1:0][LEN_BITS-1:0]          prefix_len;
      logic [FIELDS-1:0]                        wildcard_mask;
      logic signed [PRIO_BITS-1:0]              rule_priority;
      logic [VALUE_PORT_BITS-1:0]               rule_value;
   } req_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan_step;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       sealed;
      logic       count_zero;
      logic       scan_end;
      logic       out_free;
   } stat_type;

endpackage

@@ rtl/pprc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pprc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/pprc_ctrl.sv @@
// Controller state machine: sequences accept, execute, table scan and result push.
module pprc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pprc_pkg::stat_type stat,
   output pprc_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       need_scan;

   assign need_scan = (stat.action == pprc_pkg::ACT_LOOKUP) && stat.sealed && !stat.count_zero;

   assign req_ready     = (state_ff == S_IDLE);
   assign cmd.load      = (state_ff == S_IDLE) && req_valid;
   assign cmd.exec      = (state_ff == S_EXEC);
   assign cmd.scan_step = (state_ff == S_SCAN);
   assign cmd.push      = (state_ff == S_PUSH) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = need_scan ? S_SCAN : S_PUSH;
         end
         S_SCAN: begin
            // The last rule read is compared at the same edge that leaves this state.
            if (stat.scan_end) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/pprc_dp.sv @@
// Datapath: request latch, rule table, scan compare unit and output register.
module pprc_dp #(
   parameter int RULE_SLOTS = 64,
   parameter int NUM_KEYS   = 4,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pprc_pkg::req_type                       req,
   input  pprc_pkg::cmd_type                       cmd,
   output pprc_pkg::stat_type                      stat,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_matched,
   output logic [pprc_pkg::VALUE_PORT_BITS-1:0]    rsp_match_value
);

   localparam int CW       = $clog2(RULE_SLOTS + 1);
   localparam int AW       = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int LB       = pprc_pkg::LEN_BITS;
   localparam int PB       = pprc_pkg::PRIO_BITS;
   localparam int LEN_OFS  = NUM_KEYS * KEY_BITS;
   localparam int PRIO_OFS = LEN_OFS + NUM_KEYS * LB;
   localparam int VAL_OFS  = PRIO_OFS + PB;
   localparam int WORD_W   = VAL_OFS + VALUE_BITS;
   localparam logic [KEY_BITS-1:0] KEY_ONES = {KEY_BITS{1'b1}};

   // Latched request word.
   logic [1:0]                          action_ff, action_in;
   logic [NUM_KEYS-1:0][KEY_BITS-1:0]   key_ff, key_in;
   logic [NUM_KEYS-1:0][LB-1:0]         len_ff, len_in;
   logic [NUM_KEYS-1:0]                 wild_ff, wild_in;
   logic signed [PB-1:0]                prio_ff, prio_in;
   logic [VALUE_BITS-1:0]               val_ff, val_in;

   // Table bookkeeping.
   logic [CW-1:0]                       count_ff, count_in;
   logic                                sealed_ff, sealed_in;
   logic signed [PB-1:0]                high_ff, high_in;

   // Scan state.
   logic [CW-1:0]                       idx_ff, idx_in;
   logic                                cmp_vld_ff, cmp_vld_in;
   logic                                found_ff, found_in;
   logic signed [PB-1:0]                best_prio_ff, best_prio_in;
   logic [VALUE_BITS-1:0]               best_val_ff, best_val_in;
   logic [1:0]                          res_status_ff, res_status_in;

   // Output register.
   logic                                out_vld_ff, out_vld_in;
   logic [1:0]                          out_status_ff, out_status_in;
   logic                                out_matched_ff, out_matched_in;
   logic [pprc_pkg::VALUE_PORT_BITS-1:0] out_value_ff, out_value_in;

   logic                                is_add;
   logic                                full;
   logic signed [PB-1:0]                next_prio;
   logic signed [PB-1:0]                new_prio;
   logic                                wr_en;
   logic [WORD_W-1:0]                   wr_data;
   logic                                rd_en;
   logic [WORD_W-1:0]                   rd_data;
   logic                                scan_end;
   logic [NUM_KEYS-1:0]                 key_hit;
   logic signed [PB-1:0]                rd_prio;
   logic [VALUE_BITS-1:0]               rd_val;
   logic                                take;

   assign is_add    = (action_ff == pprc_pkg::ACT_ADD) || (action_ff == pprc_pkg::ACT_ADD_NEXT);
   assign full      = (count_ff == CW'(RULE_SLOTS));
   assign next_prio = (high_ff == pprc_pkg::PRIO_MAX) ? high_ff : high_ff + 32'sd1;
   assign new_prio  = (action_ff == pprc_pkg::ACT_ADD) ? prio_ff : next_prio;
   assign wr_en     = cmd.exec && is_add && !sealed_ff && !full;
   assign scan_end  = (idx_ff == count_ff);
   assign rd_en     = cmd.scan_step && !scan_end;

   always_comb begin
      wr_data = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         wr_data[i*KEY_BITS +: KEY_BITS] = key_ff[i];
         wr_data[LEN_OFS + i*LB +: LB]   = len_ff[i];
      end
      wr_data[PRIO_OFS +: PB]        = new_prio;
      wr_data[VAL_OFS +: VALUE_BITS] = val_ff;
   end

   pprc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RULE_SLOTS)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // A prefix length at or above the key width shifts the ones out and compares the whole key.
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         key_hit[i] = wild_ff[i] ||
                      (((key_ff[i] ^ rd_data[i*KEY_BITS +: KEY_BITS]) &
                        ~(KEY_ONES >> rd_data[LEN_OFS + i*LB +: LB])) == '0);
      end
   end

   assign rd_prio = signed'(rd_data[PRIO_OFS +: PB]);
   assign rd_val  = rd_data[VAL_OFS +: VALUE_BITS];
   // Strictly greater keeps the earlier rule on a tie.
   assign take    = cmp_vld_ff && (&key_hit) && (!found_ff || (rd_prio > best_prio_ff));

   always_comb begin
      action_in = action_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      wild_in   = wild_ff;
      prio_in   = prio_ff;
      val_in    = val_ff;
      if (cmd.load) begin
         action_in = req.action;
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_in[i] = KEY_BITS'(req.key[i]);
            len_in[i] = req.prefix_len[i];
         end
         wild_in = req.wildcard_mask[NUM_KEYS-1:0];
         prio_in = req.rule_priority;
         val_in  = VALUE_BITS'(req.rule_value);
      end
   end

   always_comb begin
      count_in      = count_ff;
      sealed_in     = sealed_ff;
      high_in       = high_ff;
      res_status_in = res_status_ff;
      if (wr_en) begin
         count_in = count_ff + CW'(1);
         if (new_prio > high_ff) high_in = new_prio;
      end
      if (cmd.exec) begin
         case (action_ff)
            pprc_pkg::ACT_ADD, pprc_pkg::ACT_ADD_NEXT: begin
               if (sealed_ff)  res_status_in = pprc_pkg::STS_PHASE;
               else if (full)  res_status_in = pprc_pkg::STS_FULL;
               else            res_status_in = pprc_pkg::STS_OK;
            end
            pprc_pkg::ACT_SEAL: begin
               sealed_in     = 1'b1;
               res_status_in = pprc_pkg::STS_OK;
            end
            default: begin
               res_status_in = sealed_ff ? pprc_pkg::STS_NOMATCH : pprc_pkg::STS_PHASE;
            end
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      cmp_vld_in   = rd_en;
      found_in     = found_ff;
      best_prio_in = best_prio_ff;
      best_val_in  = best_val_ff;
      if (cmd.exec) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else if (rd_en) begin
         idx_in = idx_ff + CW'(1);
      end
      if (take) begin
         found_in     = 1'b1;
         best_prio_in = rd_prio;
         best_val_in  = rd_val;
      end
   end

   always_comb begin
      out_vld_in     = out_vld_ff && !rsp_ready;
      out_status_in  = out_status_ff;
      out_matched_in = out_matched_ff;
      out_value_in   = out_value_ff;
      if (cmd.push) begin
         out_vld_in     = 1'b1;
         out_status_in  = found_ff ? pprc_pkg::STS_OK : res_status_ff;
         out_matched_in = found_ff;
         out_value_in   = found_ff ? pprc_pkg::value_word_type'(best_val_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      key_ff         <= key_in;
      len_ff         <= len_in;
      wild_ff        <= wild_in;
      prio_ff        <= prio_in;
      val_ff         <= val_in;
      best_prio_ff   <= best_prio_in;
      best_val_ff    <= best_val_in;
      res_status_ff  <= res_status_in;
      out_status_ff  <= out_status_in;
      out_matched_ff <= out_matched_in;
      out_value_ff   <= out_value_in;
      idx_ff         <= idx_in;
      if (reset) begin
         count_ff   <= '0;
         sealed_ff  <= 1'b0;
         high_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sealed_ff  <= sealed_in;
         high_ff    <= high_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign stat.action     = action_ff;
   assign stat.sealed     = sealed_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_end   = scan_end;
   assign stat.out_free   = !out_vld_ff || rsp_ready;

   assign rsp_valid       = out_vld_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_matched     = out_matched_ff;
   assign rsp_match_value = out_value_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RULE_SLOTS))
      else $error("rule count beyond table depth");

   a_sealed_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(sealed_ff))
      else $error("table unsealed without reset");

   a_frozen_table: assert property (@(posedge clock) disable iff (reset)
      sealed_ff |=> $stable(count_ff))
      else $error("rule added after sealing");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> count_ff != '0)
      else $error("scan started on an empty table");

endmodule

@@ rtl/priority_prefix_rule_classifier.sv @@
// Top level of the priority prefix rule classifier: ports, controller and datapath.
//
// Usage: every request word on the req_ channel carries an action. Add actions
// (with an explicit priority, or at the highest priority so far plus one) store a
// rule of four prefix keys, a priority and a value; seal closes the table; lookup
// returns the value of the highest-priority rule whose unmasked key prefixes all
// match, the earlier rule winning a tie. Each request yields exactly one word on
// the rsp_ channel with status, matched flag and match value.
// Add and seal execute and then load the response register; a lookup on a sealed,
// non-empty table first scans every stored rule, since the rule memory is read
// one rule per cycle through its single read port and each rule is compared
// against the best match so far. One request is in flight at a time, so a new
// request is accepted only once the last one's response has been loaded.
// Reset (synchronous, active high) empties and unseals the table and clears the
// highest priority to zero; the rule memory itself is not cleared.
// A stalled receiver holds the response in the output register; the block still
// accepts and processes the next request, then waits until that register frees.
module priority_prefix_rule_classifier #(
   parameter int RULE_SLOTS = 64,
   parameter int NUM_KEYS   = 4,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_key_0,
   input  logic [31:0]        req_key_1,
   input  logic [31:0]        req_key_2,
   input  logic [31:0]        req_key_3,
   input  logic [5:0]         req_prefix_len_0,
   input  logic [5:0]         req_prefix_len_1,
   input  logic [5:0]         req_prefix_len_2,
   input  logic [5:0]         req_prefix_len_3,
   input  logic [3:0]         req_wildcard_mask,
   input  logic signed [31:0] req_rule_priority,
   input  logic [31:0]        req_rule_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_matched,
   output logic [31:0]        rsp_match_value
);

   pprc_pkg::req_type  req;
   pprc_pkg::cmd_type  cmd;
   pprc_pkg::stat_type stat;

   assign req.action        = req_action;
   assign req.key[0]        = req_key_0;
   assign req.key[1]        = req_key_1;
   assign req.key[2]        = req_key_2;
   assign req.key[3]        = req_key_3;
   assign req.prefix_len[0] = req_prefix_len_0;
   assign req.prefix_len[1] = req_prefix_len_1;
   assign req.prefix_len[2] = req_prefix_len_2;
   assign req.prefix_len[3] = req_prefix_len_3;
   assign req.wildcard_mask = req_wildcard_mask;
   assign req.rule_priority = req_rule_priority;
   assign req.rule_value    = req_rule_value;

   pprc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pprc_dp #(
      .RULE_SLOTS (RULE_SLOTS),
      .NUM_KEYS   (NUM_KEYS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_matched     (rsp_matched),
      .rsp_match_value (rsp_match_value)
   );

endmodule
